/* hw/rtl/pss_pkg.sv */
`timescale 1ns / 1ps
// shared types and constants for the point to segment squared distance block
// no dependencies
package pss_pkg;

    localparam int DIST_WIDTH = 49;

    typedef enum logic [1:0] {
        REGION_DEGEN    = 2'd0,
        REGION_START    = 2'd1,
        REGION_END      = 2'd2,
        REGION_INTERIOR = 2'd3
    } region_t;

    typedef struct packed {
        logic    valid;
        region_t region;
    } pss_ctl_t;

endpackage

/* hw/rtl/pss_front.sv */
`timescale 1ns / 1ps
// front end: coordinate differences, products, sums and case selection (four stages)
// depends on pss_pkg
module pss_front #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic signed [COORD_WIDTH-1:0] query_x,
    input  logic signed [COORD_WIDTH-1:0] query_y,
    input  logic signed [COORD_WIDTH-1:0] start_x,
    input  logic signed [COORD_WIDTH-1:0] start_y,
    input  logic signed [COORD_WIDTH-1:0] end_x,
    input  logic signed [COORD_WIDTH-1:0] end_y,
    output pss_pkg::pss_ctl_t             ctl_out,
    output logic [2*COORD_WIDTH:0]        len2,
    output logic [2*COORD_WIDTH:0]        mag,
    output logic [2*COORD_WIDTH:0]        base_dist
);
    import pss_pkg::*;

    localparam int DW = COORD_WIDTH + 1;
    localparam int MW = 2 * DW;
    localparam int P  = 2 * COORD_WIDTH + 1;

    // stage 1: differences
    logic signed [DW-1:0] dx_reg, dy_reg, ax_reg, ay_reg, bx_reg, by_reg;
    logic signed [DW-1:0] dx_next, dy_next, ax_next, ay_next, bx_next, by_next;
    logic                 v1_reg;

    assign dx_next = DW'(end_x) - DW'(start_x);
    assign dy_next = DW'(end_y) - DW'(start_y);
    assign ax_next = DW'(query_x) - DW'(start_x);
    assign ay_next = DW'(query_y) - DW'(start_y);
    assign bx_next = DW'(query_x) - DW'(end_x);
    assign by_next = DW'(query_y) - DW'(end_y);

    // stage 2: products
    logic signed [MW-1:0] dxdx_reg, dydy_reg, axdx_reg, aydy_reg, dxay_reg, dyax_reg;
    logic signed [MW-1:0] axax_reg, ayay_reg, bxbx_reg, byby_reg;
    logic                 degen2_reg;
    logic                 v2_reg;

    // stage 3: sums
    logic [P-1:0]         len2_reg, da_reg, db_reg;
    logic signed [MW-1:0] dot_reg, cross_reg;
    logic                 degen3_reg;
    logic                 v3_reg;

    // stage 4: case selection
    pss_ctl_t             ctl_reg, ctl_next;
    logic [P-1:0]         len2_out_reg, mag_reg, dist_reg;
    logic [P-1:0]         mag_next, dist_next;
    logic signed [MW-1:0] cross_abs;
    logic                 dot_neg, dot_gt;

    assign dot_neg   = dot_reg[MW-1];
    assign dot_gt    = dot_reg > $signed({1'b0, len2_reg});
    assign cross_abs = cross_reg[MW-1] ? -cross_reg : cross_reg;
    assign mag_next  = cross_abs[P-1:0];

    always_comb
    begin
        ctl_next.valid = v3_reg;
        priority if (degen3_reg)
        begin
            ctl_next.region = REGION_DEGEN;
        end
        else if (dot_neg)
        begin
            ctl_next.region = REGION_START;
        end
        else if (dot_gt)
        begin
            ctl_next.region = REGION_END;
        end
        else
        begin
            ctl_next.region = REGION_INTERIOR;
        end
        dist_next = (ctl_next.region == REGION_END) ? db_reg : da_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            ctl_reg <= '0;
        end
        else if (en)
        begin
            v1_reg  <= in_valid;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_next;
            dy_reg <= dy_next;
            ax_reg <= ax_next;
            ay_reg <= ay_next;
            bx_reg <= bx_next;
            by_reg <= by_next;

            dxdx_reg   <= MW'(dx_reg) * MW'(dx_reg);
            dydy_reg   <= MW'(dy_reg) * MW'(dy_reg);
            axdx_reg   <= MW'(ax_reg) * MW'(dx_reg);
            aydy_reg   <= MW'(ay_reg) * MW'(dy_reg);
            dxay_reg   <= MW'(dx_reg) * MW'(ay_reg);
            dyax_reg   <= MW'(dy_reg) * MW'(ax_reg);
            axax_reg   <= MW'(ax_reg) * MW'(ax_reg);
            ayay_reg   <= MW'(ay_reg) * MW'(ay_reg);
            bxbx_reg   <= MW'(bx_reg) * MW'(bx_reg);
            byby_reg   <= MW'(by_reg) * MW'(by_reg);
            degen2_reg <= (dx_reg == '0) && (dy_reg == '0);

            // squares are nonnegative and their sums stay below 2^P
            len2_reg   <= P'(dxdx_reg + dydy_reg);
            da_reg     <= P'(axax_reg + ayay_reg);
            db_reg     <= P'(bxbx_reg + byby_reg);
            dot_reg    <= axdx_reg + aydy_reg;
            cross_reg  <= dxay_reg - dyax_reg;
            degen3_reg <= degen2_reg;

            len2_out_reg <= len2_reg;
            mag_reg      <= mag_next;
            dist_reg     <= dist_next;
        end
    end

    assign ctl_out   = ctl_reg;
    assign len2      = len2_out_reg;
    assign mag       = mag_reg;
    assign base_dist = dist_reg;

endmodule

/* hw/rtl/pss_square.sv */
`timescale 1ns / 1ps
// squares the cross product magnitude from half-width partial products (two stages)
// and picks dividend and divisor for the divider; depends on pss_pkg
module pss_square #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  pss_pkg::pss_ctl_t               ctl_in,
    input  logic [2*COORD_WIDTH:0]          len2,
    input  logic [2*COORD_WIDTH:0]          mag,
    input  logic [2*COORD_WIDTH:0]          base_dist,
    output pss_pkg::pss_ctl_t               ctl_out,
    output logic [2*(2*COORD_WIDTH+1)-1:0]  dividend,
    output logic [2*COORD_WIDTH:0]          divisor
);
    import pss_pkg::*;

    localparam int P  = 2 * COORD_WIDTH + 1;
    localparam int H  = COORD_WIDTH + 1;
    localparam int HW = P - H;
    localparam int SW = 2 * P;

    logic [H-1:0]    m0;
    logic [HW-1:0]   m1;

    pss_ctl_t        ctl1_reg, ctl2_reg;
    logic [2*H-1:0]  p00_reg;
    logic [H+HW-1:0] p01_reg;
    logic [2*HW-1:0] p11_reg;
    logic [P-1:0]    len2_reg, dist_reg;

    logic [SW-1:0]   sq_next, dividend_next;
    logic [P-1:0]    divisor_next;
    logic [SW-1:0]   dividend_reg;
    logic [P-1:0]    divisor_reg;
    logic            interior;

    assign m0 = mag[H-1:0];
    assign m1 = mag[P-1:H];

    assign sq_next = (SW'(p11_reg) << (2 * H))
                   + (SW'(p01_reg) << (H + 1))
                   + SW'(p00_reg);

    // outside the interior case the divider sees dist / 1
    assign interior      = (ctl1_reg.region == REGION_INTERIOR);
    assign dividend_next = interior ? sq_next : SW'(dist_reg);
    assign divisor_next  = interior ? len2_reg : P'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
        end
        else if (en)
        begin
            ctl1_reg <= ctl_in;
            ctl2_reg <= ctl1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p00_reg      <= (2*H)'(m0) * (2*H)'(m0);
            p01_reg      <= (H+HW)'(m0) * (H+HW)'(m1);
            p11_reg      <= (2*HW)'(m1) * (2*HW)'(m1);
            len2_reg     <= len2;
            dist_reg     <= base_dist;
            dividend_reg <= dividend_next;
            divisor_reg  <= divisor_next;
        end
    end

    assign ctl_out  = ctl2_reg;
    assign dividend = dividend_reg;
    assign divisor  = divisor_reg;

endmodule

/* hw/rtl/pss_divider.sv */
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage
// depends on pss_pkg
module pss_divider #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           en,
    input  pss_pkg::pss_ctl_t              ctl_in,
    input  logic [2*(2*COORD_WIDTH+1)-1:0] dividend,
    input  logic [2*COORD_WIDTH:0]         divisor,
    output pss_pkg::pss_ctl_t              ctl_out,
    output logic [2*COORD_WIDTH:0]         quotient
);
    import pss_pkg::*;

    localparam int P = 2 * COORD_WIDTH + 1;

    // the quotient is known to fit P bits, so the upper dividend half is already
    // below the divisor and serves as the starting remainder
    logic [P-1:0] rem_reg [P];
    logic [P-1:0] qd_reg  [P];
    logic [P-1:0] div_reg [P];
    pss_ctl_t     ctl_reg [P];

    for (genvar i = 0; i < P; i++)
    begin : g_stage
        logic [P-1:0] rem_in, qd_in, div_in;
        pss_ctl_t     ctl_next;
        logic [P:0]   trial;
        logic         take;
        logic [P-1:0] rem_next, qd_next;

        if (i == 0)
        begin : g_first
            assign rem_in   = dividend[2*P-1:P];
            assign qd_in    = dividend[P-1:0];
            assign div_in   = divisor;
            assign ctl_next = ctl_in;
        end
        else
        begin : g_rest
            assign rem_in   = rem_reg[i-1];
            assign qd_in    = qd_reg[i-1];
            assign div_in   = div_reg[i-1];
            assign ctl_next = ctl_reg[i-1];
        end

        assign trial    = {rem_in, qd_in[P-1]} - {1'b0, div_in};
        assign take     = ~trial[P];
        assign rem_next = take ? trial[P-1:0] : {rem_in[P-2:0], qd_in[P-1]};
        // dividend bits leave at the top while quotient bits enter at the bottom
        assign qd_next  = {qd_in[P-2:0], take};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                ctl_reg[i] <= '0;
            end
            else if (en)
            begin
                ctl_reg[i] <= ctl_next;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i] <= rem_next;
                qd_reg[i]  <= qd_next;
                div_reg[i] <= div_in;
            end
        end

        a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
            ctl_reg[i].valid |-> (rem_reg[i] < div_reg[i]))
            else $error("divider remainder not below divisor");
    end

    assign ctl_out  = ctl_reg[P-1];
    assign quotient = qd_reg[P-1];

    a_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (en && ctl_in.valid) |-> (divisor != '0))
        else $error("zero divisor entering divider");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(ctl_reg[P-1]) && $stable(qd_reg[P-1]))
        else $error("divider output moved during stall");

endmodule

/* hw/rtl/point_segment_sq_distance.sv */
`timescale 1ns / 1ps
// top level of the point to segment squared distance pipeline
// depends on pss_pkg, pss_front, pss_square, pss_divider
//
// Computes the minimal squared distance from query point r to the segment from
// start point p to end point q, with twice the coordinate fraction bits, plus a
// region code (degenerate segment, nearest start, nearest end, interior). The
// interior case divides the squared cross product by the squared segment length,
// truncated. One request is taken every cycle while the pipeline is not stalled;
// the divider retires one quotient bit per stage over 2*COORD_WIDTH+1 stages. The
// whole pipeline stalls together only when the output register holds an untaken
// result and another finished result is waiting behind it.
module point_segment_sq_distance #(
    parameter int COORD_WIDTH = 24
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 query_valid,
    output logic                                 query_ready,
    input  logic signed [COORD_WIDTH-1:0]        query_x,
    input  logic signed [COORD_WIDTH-1:0]        query_y,
    input  logic signed [COORD_WIDTH-1:0]        start_x,
    input  logic signed [COORD_WIDTH-1:0]        start_y,
    input  logic signed [COORD_WIDTH-1:0]        end_x,
    input  logic signed [COORD_WIDTH-1:0]        end_y,
    output logic                                 result_valid,
    input  logic                                 result_ready,
    output logic [pss_pkg::DIST_WIDTH-1:0]       dist_sq,
    output logic [1:0]                           region
);
    import pss_pkg::*;

    localparam int P  = 2 * COORD_WIDTH + 1;
    localparam int SW = 2 * P;

    logic          advance;
    pss_ctl_t      front_ctl, square_ctl, div_ctl;
    logic [P-1:0]  len2, mag, base_dist, divisor, quotient;
    logic [SW-1:0] dividend;

    logic                  out_valid_reg, out_valid_next;
    logic [DIST_WIDTH-1:0] dist_sq_reg;
    region_t               region_reg;

    // pipeline moves unless a finished result waits behind an untaken one
    assign advance     = !div_ctl.valid || !out_valid_reg || result_ready;
    assign query_ready = advance;

    pss_front #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .in_valid  (query_valid),
        .query_x   (query_x),
        .query_y   (query_y),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .ctl_out   (front_ctl),
        .len2      (len2),
        .mag       (mag),
        .base_dist (base_dist)
    );

    pss_square #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_square (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (advance),
        .ctl_in    (front_ctl),
        .len2      (len2),
        .mag       (mag),
        .base_dist (base_dist),
        .ctl_out   (square_ctl),
        .dividend  (dividend),
        .divisor   (divisor)
    );

    pss_divider #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (advance),
        .ctl_in   (square_ctl),
        .dividend (dividend),
        .divisor  (divisor),
        .ctl_out  (div_ctl),
        .quotient (quotient)
    );

    always_comb
    begin
        if (advance && div_ctl.valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && div_ctl.valid)
        begin
            dist_sq_reg <= DIST_WIDTH'(quotient);
            region_reg  <= div_ctl.region;
        end
    end

    assign result_valid = out_valid_reg;
    assign dist_sq      = dist_sq_reg;
    assign region       = region_reg;

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !query_ready |-> (result_valid && !result_ready))
        else $error("input stalled without a blocked result");

    a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(div_ctl.valid))
        else $error("result appeared without a finished request");

    a_keep_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready && div_ctl.valid) |=> div_ctl.valid)
        else $error("finished request lost during stall");

endmodule

/* test/tb_point_segment_sq_distance.sv */
`timescale 1ns / 1ps
// self-checking testbench for point_segment_sq_distance: directed corners plus random queries
// depends on pss_pkg and the point_segment_sq_distance rtl
module tb_point_segment_sq_distance;

    import pss_pkg::*;

    localparam int COORD_WIDTH = 24;
    localparam int PIPE_LATENCY = 2 * COORD_WIDTH + 8;
    localparam int RANDOM_QUERIES = 480;
    localparam int DRAIN_EVERY = 120;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    localparam coord_t COORD_MAX = 24'sh7FFFFF;
    localparam coord_t COORD_MIN = 24'sh800000;

    typedef struct packed {
        logic [DIST_WIDTH-1:0] dist_val;
        region_t               zone;
    } sq_dist_t;

    typedef enum int {
        MIX_WIDE,
        MIX_LOCAL,
        MIX_DEGEN,
        MIX_ON_START,
        MIX_ON_END,
        MIX_COLLINEAR,
        MIX_CORNER,
        MIX_SCALED
    } mix_kind_t;

    typedef enum int {
        RX_FREE,
        RX_RANDOM,
        RX_PATTERN,
        RX_BLOCK
    } rx_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  query_valid;
    logic                  query_ready;
    coord_t                query_x;
    coord_t                query_y;
    coord_t                start_x;
    coord_t                start_y;
    coord_t                end_x;
    coord_t                end_y;
    logic                  result_valid;
    logic                  result_ready = 1'b0;
    logic [DIST_WIDTH-1:0] dist_sq;
    logic [1:0]            region;

    sq_dist_t pending_dists[$];
    int       mismatch_count = 0;
    int       results_checked = 0;
    int       queries_sent;
    int       region_hits[4] = '{default: 0};
    int       burst_left;
    rx_mode_t rx_mode = RX_FREE;
    int       rx_left = 0;
    int       rx_phase = 0;

    point_segment_sq_distance #(
        .COORD_WIDTH(COORD_WIDTH)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .query_valid(query_valid),
        .query_ready(query_ready),
        .query_x(query_x),
        .query_y(query_y),
        .start_x(start_x),
        .start_y(start_y),
        .end_x(end_x),
        .end_y(end_y),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .dist_sq(dist_sq),
        .region(region)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // squared distance from r to segment pq, classified by projection without division
    function automatic sq_dist_t nearest_sq_dist(input coord_t rx, input coord_t ry,
                                                 input coord_t px, input coord_t py,
                                                 input coord_t qx, input coord_t qy);
        longint       dx;
        longint       dy;
        longint       ax;
        longint       ay;
        longint       bx;
        longint       by;
        longint       len2;
        longint       dot;
        longint       cross_prod;
        logic [63:0]  sum;
        logic [63:0]  mag;
        logic [127:0] quotient;
        sq_dist_t     res;
        dx = longint'(qx) - longint'(px);
        dy = longint'(qy) - longint'(py);
        ax = longint'(rx) - longint'(px);
        ay = longint'(ry) - longint'(py);
        bx = longint'(rx) - longint'(qx);
        by = longint'(ry) - longint'(qy);
        len2 = dx * dx + dy * dy;
        dot = ax * dx + ay * dy;
        if (len2 == 0)
        begin
            sum = ax * ax + ay * ay;
            res.zone = REGION_DEGEN;
        end
        else if (dot < 0)
        begin
            sum = ax * ax + ay * ay;
            res.zone = REGION_START;
        end
        else if (dot > len2)
        begin
            sum = bx * bx + by * by;
            res.zone = REGION_END;
        end
        else
        begin
            cross_prod = dx * ay - dy * ax;
            mag = (cross_prod < 0) ? -cross_prod : cross_prod;
            // cross squared needs up to 98 bits, divide at full width then truncate
            quotient = ({64'd0, mag} * {64'd0, mag}) / {64'd0, len2};
            sum = quotient[63:0];
            res.zone = REGION_INTERIOR;
        end
        res.dist_val = sum[DIST_WIDTH-1:0];
        return res;
    endfunction

    function automatic coord_t rand_coord();
        return coord_t'($urandom);
    endfunction

    function automatic int rand_near(input int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic coord_t corner_coord();
        case ($urandom_range(0, 4))
            0: return COORD_MIN;
            1: return COORD_MAX;
            2: return '0;
            3: return '1;
            default: return rand_coord();
        endcase
    endfunction

    task automatic send_query(input coord_t rx, input coord_t ry, input coord_t px,
                              input coord_t py, input coord_t qx, input coord_t qy);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 32);
            if (gap > 0)
            begin
                @(negedge clk);
                query_valid = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        query_valid = 1'b1;
        query_x = rx;
        query_y = ry;
        start_x = px;
        start_y = py;
        end_x = qx;
        end_y = qy;
        do
            @(posedge clk);
        while (!query_ready);
        pending_dists.insert(pending_dists.size(), nearest_sq_dist(rx, ry, px, py, qx, qy));
        queries_sent++;
    endtask

    // hold off new requests until the pipeline has returned everything
    task automatic wait_all_results();
        @(negedge clk);
        query_valid = 1'b0;
        while (pending_dists.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_degenerate();
        send_query('0, '0, '0, '0, '0, '0);
        send_query(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN);
        send_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX);
        send_query(24'sd5, -24'sd7, -24'sd3, 24'sd2, -24'sd3, 24'sd2);
    endtask

    task automatic test_endpoint_regions();
        send_query(-24'sd256, 24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        send_query(24'sd512, 24'sd100, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        send_query(-24'sd1, -24'sd1, 24'sd0, 24'sd0, 24'sd1, 24'sd0);
        send_query(24'sd257, 24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
    endtask

    task automatic test_interior_edges();
        send_query(24'sd128, 24'sd256, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        // projection lands exactly on p, then exactly on q
        send_query(24'sd0, 24'sd300, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        send_query(24'sd256, 24'sd300, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
        // 25/10 must truncate to 2
        send_query(24'sd1, 24'sd2, 24'sd0, 24'sd0, 24'sd3, 24'sd1);
        send_query(24'sd100, 24'sd0, 24'sd0, 24'sd0, 24'sd256, 24'sd0);
    endtask

    task automatic test_extremes();
        send_query(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
        send_query(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX);
        send_query(COORD_MAX, COORD_MAX, COORD_MIN, COORD_MIN, '0, '0);
        send_query(COORD_MIN, COORD_MIN, '0, '0, COORD_MAX, COORD_MAX);
        send_query('0, COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, COORD_MAX);
        send_query(24'shAAAAAA, 24'sh555555, 24'sh555555, 24'shAAAAAA,
                   24'shAAAAAA, 24'shAAAAAA);
        send_query('1, '0, '1, '1, '0, '0);
    endtask

    task automatic test_random_mix();
        mix_kind_t kind;
        int        cx;
        int        cy;
        int        dx;
        int        dy;
        int        k;
        coord_t    rx;
        coord_t    ry;
        coord_t    px;
        coord_t    py;
        coord_t    qx;
        coord_t    qy;
        for (int i = 0; i < RANDOM_QUERIES; i++)
        begin
            kind = mix_kind_t'($urandom_range(0, MIX_SCALED));
            // small base segment shared by the constructed cases
            cx = rand_near(1 << 20);
            cy = rand_near(1 << 20);
            dx = rand_near(1 << 10);
            dy = rand_near(1 << 10);
            if (dx == 0 && dy == 0)
                dx = 1;
            k = rand_near(1 << 8);
            px = coord_t'(cx);
            py = coord_t'(cy);
            qx = coord_t'(cx + dx);
            qy = coord_t'(cy + dy);
            rx = rand_coord();
            ry = rand_coord();
            case (kind)
                MIX_WIDE:
                begin
                    px = rand_coord();
                    py = rand_coord();
                    qx = rand_coord();
                    qy = rand_coord();
                end
                MIX_LOCAL:
                begin
                    cx = rand_near(1 << 22);
                    cy = rand_near(1 << 22);
                    px = coord_t'(cx + rand_near(1 << 12));
                    py = coord_t'(cy + rand_near(1 << 12));
                    qx = coord_t'(cx + rand_near(1 << 12));
                    qy = coord_t'(cy + rand_near(1 << 12));
                    rx = coord_t'(cx + rand_near(1 << 13));
                    ry = coord_t'(cy + rand_near(1 << 13));
                end
                MIX_DEGEN:
                begin
                    if ($urandom_range(0, 1) == 1)
                    begin
                        px = rand_coord();
                        py = rand_coord();
                    end
                    qx = px;
                    qy = py;
                end
                MIX_ON_START:
                begin
                    rx = coord_t'(cx - k * dy);
                    ry = coord_t'(cy + k * dx);
                end
                MIX_ON_END:
                begin
                    rx = coord_t'(cx + dx - k * dy);
                    ry = coord_t'(cy + dy + k * dx);
                end
                MIX_COLLINEAR:
                begin
                    k = int'($urandom_range(0, 7)) - 3;
                    rx = coord_t'(cx + k * dx);
                    ry = coord_t'(cy + k * dy);
                end
                MIX_CORNER:
                begin
                    rx = corner_coord();
                    ry = corner_coord();
                    px = corner_coord();
                    py = corner_coord();
                    qx = corner_coord();
                    qy = corner_coord();
                end
                default:
                begin
                    rx = rand_coord() >>> $urandom_range(0, 20);
                    ry = rand_coord() >>> $urandom_range(0, 20);
                    px = rand_coord() >>> $urandom_range(0, 20);
                    py = rand_coord() >>> $urandom_range(0, 20);
                    qx = rand_coord() >>> $urandom_range(0, 20);
                    qy = rand_coord() >>> $urandom_range(0, 20);
                end
            endcase
            send_query(rx, ry, px, py, qx, qy);
            if ((i + 1) % DRAIN_EVERY == 0)
                wait_all_results();
        end
    endtask

    // receiver backpressure: free running, coin flips, fixed pattern and solid stalls
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_left == 0)
            begin
                rx_mode = rx_mode_t'($urandom_range(0, RX_BLOCK));
                rx_left = (rx_mode == RX_BLOCK) ? $urandom_range(1, 40)
                                                : $urandom_range(20, 200);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_FREE:    result_ready <= 1'b1;
                RX_RANDOM:  result_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: result_ready <= (rx_phase % 3) != 0;
                default:    result_ready <= 1'b0;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_result
        sq_dist_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_checked++;
            if (pending_dists.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result: dist_sq=%0d region=%0d", dist_sq, region);
            end
            else
            begin
                want = pending_dists.pop_front();
                region_hits[want.zone]++;
                if (dist_sq !== want.dist_val || region !== want.zone)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("bad result %0d: dist_sq got %0d want %0d, %s",
                                 results_checked, dist_sq, want.dist_val,
                                 $sformatf("region got %0d want %s", region,
                                           want.zone.name()));
                end
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("point_segment_sq_distance: mismatch");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        query_valid = 1'b0;
        query_x = '0;
        query_y = '0;
        start_x = '0;
        start_y = '0;
        end_x = '0;
        end_y = '0;
        queries_sent = 0;
        burst_left = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_degenerate();
        test_endpoint_regions();
        test_interior_edges();
        test_extremes();
        wait_all_results();
        test_random_mix();
        wait_all_results();
        repeat (PIPE_LATENCY + 50) @(posedge clk);

        $display("sent %0d queries, checked %0d results", queries_sent, results_checked);
        $display("regions seen: %0d degenerate, %0d nearest start, %0d nearest end, %0d interior",
                 region_hits[REGION_DEGEN], region_hits[REGION_START],
                 region_hits[REGION_END], region_hits[REGION_INTERIOR]);
        if (mismatch_count == 0 && pending_dists.size() == 0)
            $display("point_segment_sq_distance: match");
        else
            $display("point_segment_sq_distance: mismatch");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/pss_pkg.sv
hw/rtl/pss_front.sv
hw/rtl/pss_square.sv
hw/rtl/pss_divider.sv
hw/rtl/point_segment_sq_distance.sv
test/tb_point_segment_sq_distance.sv
